### design/tvtc_pkg.sv
// ----------------------------------------------------------------------------
// tvtc_pkg
// Shared types and constants for the triangle vertex transform and cull block.
// ----------------------------------------------------------------------------
package tvtc_pkg;

    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned REG_W = 64;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic [15:0]        col_red;
        logic [15:0]        col_green;
        logic [15:0]        col_blue;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] depth_ndc;
        logic signed [31:0] clip_w;
        logic signed [31:0] recip_w;
        logic signed [31:0] u_over_w;
        logic signed [31:0] v_over_w;
        logic signed [31:0] red_over_w;
        logic signed [31:0] green_over_w;
        logic signed [31:0] blue_over_w;
        logic               last_of_triangle;
    } t_out_word;

    // Multiplier operand selects; one product per step.
    typedef enum logic [3:0] {
        MS_X0, MS_X1, MS_X2, MS_X3,
        MS_Y0, MS_Y1, MS_Y2, MS_Y3,
        MS_Z0, MS_Z1, MS_Z2, MS_Z3,
        MS_ATTR
    } t_msel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAT,       // 12 matrix products into four accumulators, then a drain step
        ST_CLIP,      // saturate rows, test clip volume, start divider
        ST_DIV,       // iterative reciprocal
        ST_RSAT,      // saturate reciprocal
        ST_ATTR,      // eight products against 1/w
        ST_VIEW,      // viewport mapping
        ST_STORE,     // hold vertex or finish triangle
        ST_EMIT       // three output words
    } t_state;

    // Attribute product indexes.
    localparam logic [2:0] AT_X = 3'd0;
    localparam logic [2:0] AT_Y = 3'd1;
    localparam logic [2:0] AT_Z = 3'd2;
    localparam logic [2:0] AT_U = 3'd3;
    localparam logic [2:0] AT_V = 3'd4;
    localparam logic [2:0] AT_R = 3'd5;
    localparam logic [2:0] AT_G = 3'd6;
    localparam logic [2:0] AT_B = 3'd7;

    typedef struct packed {
        logic       load;       // capture input word
        logic       mat_clear;  // clear accumulators
        logic       mat_step;   // one matrix product
        logic [3:0] mat_idx;
        logic       clip;       // saturate and test
        logic       div_start;
        logic       rsat;
        logic       attr_step;
        logic [2:0] attr_idx;
        logic       view;
        logic       store;      // hold vertex at count
        logic       emit_load;  // load output register
        logic [1:0] emit_idx;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last_vertex;  // count says this completes a triangle
        logic culled;       // triangle has a vertex outside
    } t_status;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) r = SAT_MAX;
        else if (v < -64'sh0000_0000_8000_0000) r = SAT_MIN;
        else r = v[31:0];
        return r;
    endfunction

    // Rounded Q16.16 product shift: add half, floor-shift by 16.
    function automatic logic signed [63:0] qround(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t >>> 16;
    endfunction

endpackage

### design/tvtc_ctrl.sv
// ----------------------------------------------------------------------------
// tvtc_ctrl
// Sequencer for one vertex: matrix products, cull test, reciprocal,
// attribute products, viewport and emission of finished triangles.
// ----------------------------------------------------------------------------
module tvtc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tvtc_pkg::t_status  i_status,
    output tvtc_pkg::t_cmd     o_cmd
);
    import tvtc_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    // Next state and counter.
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_out_valid = r_out_valid;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MAT;
                    n_cnt = '0;
                end
            end
            ST_MAT: begin
                // The last step only lets the final product reach its accumulator.
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd12) n_state = ST_CLIP;
            end
            ST_CLIP: n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_done) n_state = ST_RSAT;
            end
            ST_RSAT: begin
                n_state = ST_ATTR;
                n_cnt = '0;
            end
            ST_ATTR: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd7) n_state = ST_VIEW;
            end
            ST_VIEW: n_state = ST_STORE;
            ST_STORE: begin
                if (i_status.last_vertex && !i_status.culled) begin
                    n_state = ST_EMIT;
                    n_cnt = '0;
                    n_out_valid = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd2) begin
                        n_out_valid = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        o_in_ready = (r_state == ST_IDLE);
        o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mat_clear = o_cmd.load;
        o_cmd.mat_step = (r_state == ST_MAT) && (r_cnt != 4'd12);
        o_cmd.mat_idx = r_cnt;
        o_cmd.clip = (r_state == ST_CLIP);
        o_cmd.div_start = (r_state == ST_CLIP);
        o_cmd.rsat = (r_state == ST_RSAT);
        o_cmd.attr_step = (r_state == ST_ATTR);
        o_cmd.attr_idx = r_cnt[2:0];
        o_cmd.view = (r_state == ST_VIEW);
        o_cmd.store = (r_state == ST_STORE);
        o_cmd.emit_load = ((r_state == ST_STORE) && i_status.last_vertex &&
                           !i_status.culled) ||
                          ((r_state == ST_EMIT) && i_out_ready && r_cnt != 4'd2);
        o_cmd.emit_idx = (r_state == ST_STORE) ? 2'd0 : (r_cnt[1:0] + 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // Output words appear only while emitting.
    a_valid_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_EMIT))
        else $error("output valid outside emit");
    // No input is taken while a triangle is emitted.
    a_no_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready)
        else $error("input ready while emitting");
    // The matrix pass runs twelve product steps and one drain step.
    a_mat_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAT) |-> (r_cnt <= 4'd12))
        else $error("matrix counter overrun");
endmodule

### design/tvtc_datapath.sv
// ----------------------------------------------------------------------------
// tvtc_datapath
// Shared multiplier, row accumulators, restoring reciprocal divider,
// viewport mapping, held vertices and the output register.
// ----------------------------------------------------------------------------
module tvtc_datapath #(
    parameter int unsigned SCREEN_WIDTH  = 640,
    parameter int unsigned SCREEN_HEIGHT = 480
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tvtc_pkg::t_in_word              i_in,
    input  logic                            i_cfg_we,
    input  logic [tvtc_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tvtc_pkg::REG_W-1:0]      i_cfg_data,
    input  tvtc_pkg::t_cmd                  i_cmd,
    output tvtc_pkg::t_status               o_status,
    output tvtc_pkg::t_out_word             o_out
);
    import tvtc_pkg::*;

    localparam logic signed [14:0] SW = 15'(SCREEN_WIDTH);
    localparam logic signed [14:0] SH = 15'(SCREEN_HEIGHT);

    // Configuration registers; the reset matrix is the identity.
    logic [REG_W-1:0] r_regs [NUM_REGS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[REG_ROW0_COLS01] <= 64'h0000_0000_0001_0000;
            r_regs[REG_ROW0_COLS23] <= 64'h0000_0000_0000_0000;
            r_regs[REG_ROW1_COLS01] <= 64'h0001_0000_0000_0000;
            r_regs[REG_ROW1_COLS23] <= 64'h0000_0000_0000_0000;
            r_regs[REG_ROW2_COLS01] <= 64'h0000_0000_0000_0000;
            r_regs[REG_ROW2_COLS23] <= 64'h0000_0000_0001_0000;
            r_regs[REG_ROW3_COLS01] <= 64'h0000_0000_0000_0000;
            r_regs[REG_ROW3_COLS23] <= 64'h0001_0000_0000_0000;
        end else if (i_cfg_we) begin
            r_regs[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Captured input word.
    t_in_word r_in;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
    end

    // Coefficient lookup for the matrix step: row is idx/4, column idx%4.
    logic [1:0]         m_row, m_col;
    logic [63:0]        m_reg;
    logic signed [31:0] m_coef, m_pos;
    assign m_row = i_cmd.mat_idx[3:2];
    assign m_col = i_cmd.mat_idx[1:0];
    assign m_reg = r_regs[{m_row, m_col[1]}];
    assign m_coef = m_col[0] ? m_reg[63:32] : m_reg[31:0];
    always_comb begin
        unique case (m_row)
            2'd0:    m_pos = r_in.pos_x;
            2'd1:    m_pos = r_in.pos_y;
            default: m_pos = r_in.pos_z;
        endcase
    end

    // Clip-space rows, reciprocal and attribute operands.
    logic signed [48:0] r_acc [4];
    logic signed [31:0] r_clip [4];
    logic signed [31:0] r_rw;
    logic signed [31:0] a_op;
    always_comb begin
        unique case (i_cmd.attr_idx)
            AT_X:    a_op = r_clip[0];
            AT_Y:    a_op = r_clip[1];
            AT_Z:    a_op = r_clip[2];
            AT_U:    a_op = r_in.tex_u;
            AT_V:    a_op = r_in.tex_v;
            AT_R:    a_op = {16'd0, r_in.col_red};
            AT_G:    a_op = {16'd0, r_in.col_green};
            default: a_op = {16'd0, r_in.col_blue};
        endcase
    end

    // One shared 32x32 multiplier, product registered.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] r_prod;
    logic               r_prod_mat, r_prod_attr;
    logic [3:0]         r_prod_idx;
    assign mul_a = i_cmd.mat_step ? m_pos : a_op;
    assign mul_b = i_cmd.mat_step ? m_coef : r_rw;
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_prod_idx <= i_cmd.mat_step ? i_cmd.mat_idx : {1'b0, i_cmd.attr_idx};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_mat <= 1'b0;
            r_prod_attr <= 1'b0;
        end else begin
            r_prod_mat <= i_cmd.mat_step;
            r_prod_attr <= i_cmd.attr_step;
        end
    end

    logic signed [63:0] prod_rnd;
    assign prod_rnd = qround(r_prod);

    // Accumulate rounded products exactly; translation row preloads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_clear) begin
            r_acc[0] <= 49'(signed'(r_regs[REG_ROW3_COLS01][31:0]));
            r_acc[1] <= 49'(signed'(r_regs[REG_ROW3_COLS01][63:32]));
            r_acc[2] <= 49'(signed'(r_regs[REG_ROW3_COLS23][31:0]));
            r_acc[3] <= 49'(signed'(r_regs[REG_ROW3_COLS23][63:32]));
        end else if (r_prod_mat) begin
            r_acc[r_prod_idx[1:0]] <= r_acc[r_prod_idx[1:0]] + prod_rnd[48:0];
        end
    end

    // Cull flag and vertex count.
    logic [1:0] r_vcount;
    logic       r_any_out, r_cur_out;
    logic signed [31:0] c_sat [4];
    logic signed [32:0] neg_w;
    logic               out_now;
    always_comb begin
        for (int j = 0; j < 4; j++) c_sat[j] = sat32(64'(r_acc[j]));
        neg_w = -33'(c_sat[3]);
        out_now = (c_sat[2] < 0) || (c_sat[2] > c_sat[3]) ||
                  (33'(c_sat[0]) < neg_w) || (c_sat[0] > c_sat[3]) ||
                  (33'(c_sat[1]) < neg_w) || (c_sat[1] > c_sat[3]);
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.clip) begin
            for (int j = 0; j < 4; j++) r_clip[j] <= c_sat[j];
            r_cur_out <= out_now;
        end
    end

    // Restoring divider: 2^32 / |w|, one quotient bit per cycle.
    logic [32:0] r_rem;
    logic [33:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg, r_wzero, r_div_busy;
    logic [5:0]  r_div_cnt;
    logic [33:0] rem_sh;
    logic [32:0] dvd_bits;
    assign dvd_bits = 33'h1_0000_0000;
    assign rem_sh = {r_rem, dvd_bits[6'd32 - r_div_cnt]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt <= '0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + 6'd1;
            if (r_div_cnt == 6'd32) r_div_busy <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= c_sat[3][31];
            r_wzero <= (c_sat[3] == 0);
            r_dvs <= c_sat[3][31] ? 32'(-33'(c_sat[3])) : c_sat[3];
        end else if (r_div_busy) begin
            if (rem_sh >= {2'b0, r_dvs}) begin
                r_rem <= 33'(rem_sh - {2'b0, r_dvs});
                r_quo <= {r_quo[32:0], 1'b1};
            end else begin
                r_rem <= rem_sh[32:0];
                r_quo <= {r_quo[32:0], 1'b0};
            end
        end
    end
    assign o_status.div_done = !r_div_busy && !i_cmd.div_start;

    // Reciprocal with sign and saturation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rsat) begin
            if (r_wzero) r_rw <= SAT_MAX;
            else if (r_neg) r_rw <= sat32(-64'(r_quo));
            else r_rw <= sat32(64'(r_quo));
        end
    end

    // Attribute results, one per product.
    logic signed [31:0] r_attr [8];
    always_ff @(posedge i_clk) begin
        if (r_prod_attr) r_attr[r_prod_idx[2:0]] <= sat32(prod_rnd);
    end

    // Viewport mapping, one small multiply per axis.
    logic signed [31:0] r_sx, r_sy;
    logic signed [47:0] vx, vy;
    always_comb begin
        vx = (48'(r_attr[AT_X]) + 48'sd65536) * 48'(SW);
        vy = (48'sd65536 - 48'(r_attr[AT_Y])) * 48'(SH);
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.view) begin
            r_sx <= sat32(64'(vx >>> 1));
            r_sy <= sat32(64'(vy >>> 1));
        end
    end

    // Current vertex as an output word.
    t_out_word cur;
    always_comb begin
        cur.screen_x = r_sx;
        cur.screen_y = r_sy;
        cur.depth_ndc = r_attr[AT_Z];
        cur.clip_w = r_clip[3];
        cur.recip_w = r_rw;
        cur.u_over_w = r_attr[AT_U];
        cur.v_over_w = r_attr[AT_V];
        cur.red_over_w = r_attr[AT_R];
        cur.green_over_w = r_attr[AT_G];
        cur.blue_over_w = r_attr[AT_B];
        cur.last_of_triangle = 1'b0;
    end

    // Held vertices and count.
    t_out_word r_held [2];
    logic      last_v;
    assign last_v = r_vcount[1];
    assign o_status.last_vertex = last_v;
    assign o_status.culled = r_any_out | r_cur_out;
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !last_v) r_held[r_vcount[0]] <= cur;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_any_out <= 1'b0;
        end else if (i_cmd.store) begin
            if (last_v) begin
                r_vcount <= '0;
                r_any_out <= 1'b0;
            end else begin
                r_vcount <= r_vcount + 2'd1;
                r_any_out <= r_any_out | r_cur_out;
            end
        end
    end

    // Output register; the current vertex stays put until the third word.
    t_out_word r_out;
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            unique case (i_cmd.emit_idx)
                2'd0: r_out <= r_held[0];
                2'd1: r_out <= r_held[1];
                default: begin
                    r_out <= cur;
                    r_out.last_of_triangle <= 1'b1;
                end
            endcase
        end
    end
    assign o_out = r_out;

    // The count never reaches three.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcount != 2'd3)
        else $error("vertex count out of range");
    // A new divide never starts while one is running.
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_div_busy)
        else $error("divider restarted");
    // A store clears the count after the third vertex.
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.store && last_v) |=> (r_vcount == 2'd0 && !r_any_out))
        else $error("count did not wrap");
endmodule

### design/triangle_vertex_transform_cull.sv
// ----------------------------------------------------------------------------
// triangle_vertex_transform_cull
// Vertex transform, clip-volume cull and perspective divide for triangles.
// ----------------------------------------------------------------------------
// For each vertex word, 12 matrix products and 8 attribute products go
// through one shared 32x32 multiplier, and the reciprocal of w comes from a
// restoring divider that yields one quotient bit per cycle. The next vertex
// word is taken only once the previous one is finished.
// When the third vertex of a triangle with all vertices inside the clip
// volume is done, three output words follow, one per cycle while the sink
// is ready, and no input is taken until the last of them is delivered.
module triangle_vertex_transform_cull #(
    parameter int unsigned SCREEN_WIDTH  = 640,
    parameter int unsigned SCREEN_HEIGHT = 480
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tvtc_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tvtc_pkg::REG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tvtc_pkg::t_in_word              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tvtc_pkg::t_out_word             o_out_data
);
    import tvtc_pkg::*;

    t_cmd    cmd;
    t_status status;

    tvtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tvtc_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out      (o_out_data)
    );
endmodule
